@@ sv/hsps_pkg.sv @@
// Package for the SPS header parser: parse step codes, element ids, status codes.
// No dependencies.
`default_nettype none
package hsps_pkg;

    typedef enum logic [22:0] {
        ST_IDLE    = 23'd1 << 0,
        ST_HDR     = 23'd1 << 1,
        ST_ID      = 23'd1 << 2,
        ST_CHROMA  = 23'd1 << 3,
        ST_SEP     = 23'd1 << 4,
        ST_DL      = 23'd1 << 5,
        ST_DC      = 23'd1 << 6,
        ST_BYPASS  = 23'd1 << 7,
        ST_SCALING = 23'd1 << 8,
        ST_FNUM    = 23'd1 << 9,
        ST_POC     = 23'd1 << 10,
        ST_POCLSB  = 23'd1 << 11,
        ST_REFS    = 23'd1 << 12,
        ST_GAPS    = 23'd1 << 13,
        ST_WIDTH   = 23'd1 << 14,
        ST_HEIGHT  = 23'd1 << 15,
        ST_FMBS    = 23'd1 << 16,
        ST_MBAFF   = 23'd1 << 17,
        ST_DIRECT  = 23'd1 << 18,
        ST_CROPF   = 23'd1 << 19,
        ST_CROPV   = 23'd1 << 20,
        ST_VUI     = 23'd1 << 21,
        ST_DONE    = 23'd1 << 22
    } step_t;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_SCALING = 2'd1;
    localparam logic [1:0] STATUS_POC     = 2'd2;
    localparam logic [1:0] STATUS_LONG    = 2'd3;

    localparam int NUM_REC = 21;
    localparam int NUM_ELEM = 26;
    localparam logic [4:0] ELEM_LAST = 5'd25;

    // controller -> datapath
    typedef struct packed {
        logic       start;      // first byte: clear record, store profile
        logic       load_level;
        logic       load_byte;  // shift register load for bit walk
        logic       shift;      // advance to next bit
        logic       bit_go;     // feed current bit to ue decoder / flag
        step_t      step;       // which element the bit belongs to
        logic [4:0] rd_idx;     // output element select
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic       cur_bit;
        logic       ue_done;
        logic       ue_err;
        logic       high_prof;
        logic       chroma_is3;
        logic       val_nz;
        logic [2:0] crop_cnt;
    } dp_stat_t;

    function automatic logic is_high(input logic [7:0] p);
        is_high = (p == 8'd100) || (p == 8'd110) || (p == 8'd122) ||
                  (p == 8'd244) || (p == 8'd44) || (p == 8'd83) ||
                  (p == 8'd86) || (p == 8'd118) || (p == 8'd128);
    endfunction

endpackage
`default_nettype wire

@@ sv/hsps_datapath.sv @@
// Datapath: bit shifter, ue(v) decoder, element record and crop offsets.
// Depends on hsps_pkg.
`default_nettype none
module hsps_datapath (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [7:0]        data_byte,
    input  wire hsps_pkg::dp_cmd_t cmd,
    input  wire logic              commit,    // set finished cleanly
    output hsps_pkg::dp_stat_t     stat,
    output logic [31:0]            rd_value
);

    logic [7:0]  sh_reg;
    logic [5:0]  zrun_reg, zrun_next;
    logic [31:0] acc_reg, acc_next;
    logic [5:0]  left_reg, left_next;
    logic [31:0] rec_reg [hsps_pkg::NUM_REC];
    logic [31:0] crop_reg [4];
    logic [31:0] pend_reg [4];
    logic [2:0]  ccnt_reg;
    logic        high_reg;
    logic        vui_reg;
    logic        b;
    logic        done;
    logic        err;
    logic [31:0] v;
    logic [31:0] base;
    logic        flag_step;

    assign b = sh_reg[7];
    assign flag_step = (cmd.step == hsps_pkg::ST_SEP) || (cmd.step == hsps_pkg::ST_BYPASS) ||
                       (cmd.step == hsps_pkg::ST_SCALING) || (cmd.step == hsps_pkg::ST_GAPS) ||
                       (cmd.step == hsps_pkg::ST_FMBS) || (cmd.step == hsps_pkg::ST_MBAFF) ||
                       (cmd.step == hsps_pkg::ST_DIRECT) || (cmd.step == hsps_pkg::ST_CROPF) ||
                       (cmd.step == hsps_pkg::ST_VUI);

    always_comb
    begin
        zrun_next = zrun_reg;
        acc_next  = acc_reg;
        left_next = left_reg;
        done = 1'b0;
        err  = 1'b0;
        v    = 32'd0;
        base = (32'd1 << zrun_reg[4:0]) - 32'd1;
        if (left_reg == 6'd0) begin
            if (!b) begin
                zrun_next = zrun_reg + 6'd1;
                err = (zrun_reg == 6'd31);
            end
            else if (zrun_reg == 6'd0) begin
                done = 1'b1;
            end
            else begin
                left_next = zrun_reg;
                acc_next  = 32'd0;
            end
        end
        else begin
            acc_next  = {acc_reg[30:0], b};
            left_next = left_reg - 6'd1;
            if (left_reg == 6'd1) begin
                done = 1'b1;
                v = base + acc_next;
                zrun_next = 6'd0;
                acc_next  = 32'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            sh_reg   <= 8'd0;
            zrun_reg <= 6'd0;
            acc_reg  <= 32'd0;
            left_reg <= 6'd0;
            ccnt_reg <= 3'd0;
            high_reg <= 1'b0;
            vui_reg  <= 1'b0;
            for (int i = 0; i < hsps_pkg::NUM_REC; i++) begin
                rec_reg[i] <= 32'd0;
            end
            for (int i = 0; i < 4; i++) begin
                crop_reg[i] <= 32'd0;
                pend_reg[i] <= 32'd0;
            end
        end
        else begin
            if (cmd.start) begin
                for (int i = 1; i < hsps_pkg::NUM_REC; i++) begin
                    rec_reg[i] <= 32'd0;
                end
                for (int i = 0; i < 4; i++) begin
                    pend_reg[i] <= 32'd0;
                end
                rec_reg[0] <= {24'd0, data_byte};
                high_reg <= hsps_pkg::is_high(data_byte);
                zrun_reg <= 6'd0;
                acc_reg  <= 32'd0;
                left_reg <= 6'd0;
                ccnt_reg <= 3'd0;
                vui_reg  <= 1'b0;
            end
            if (cmd.load_level) begin
                rec_reg[1] <= {24'd0, data_byte};
            end
            if (cmd.load_byte) begin
                sh_reg <= data_byte;
            end
            else if (cmd.shift) begin
                sh_reg <= {sh_reg[6:0], 1'b0};
            end
            if (commit && rec_reg[20][0]) begin
                for (int i = 0; i < 4; i++) begin
                    crop_reg[i] <= pend_reg[i];
                end
            end
            if (commit) begin
                rec_reg[16] <= rec_reg[17][0] ? rec_reg[15] : {16'd0, rec_reg[15][14:0], 1'b0};
            end
            if (cmd.bit_go) begin
                if (!flag_step) begin
                    zrun_reg <= zrun_next;
                    acc_reg  <= acc_next;
                    left_reg <= left_next;
                end
                case (cmd.step)
                    hsps_pkg::ST_ID:      if (done) rec_reg[2] <= {24'd0, v[7:0]};
                    hsps_pkg::ST_CHROMA:  if (done) rec_reg[3] <= {24'd0, v[7:0]};
                    hsps_pkg::ST_SEP:     rec_reg[4] <= {31'd0, b};
                    hsps_pkg::ST_DL:      if (done) rec_reg[5] <= {24'd0, v[7:0] + 8'd8};
                    hsps_pkg::ST_DC:      if (done) rec_reg[6] <= {24'd0, v[7:0] + 8'd8};
                    hsps_pkg::ST_BYPASS:  rec_reg[7] <= {31'd0, b};
                    hsps_pkg::ST_SCALING: rec_reg[8] <= {31'd0, b};
                    hsps_pkg::ST_FNUM:    if (done) rec_reg[9] <= v + 32'd4;
                    hsps_pkg::ST_POC:     if (done) rec_reg[10] <= {24'd0, v[7:0]};
                    hsps_pkg::ST_POCLSB:  if (done) rec_reg[11] <= v + 32'd4;
                    hsps_pkg::ST_REFS:    if (done) rec_reg[12] <= v;
                    hsps_pkg::ST_GAPS:    rec_reg[13] <= {31'd0, b};
                    hsps_pkg::ST_WIDTH:   if (done) rec_reg[14] <= {16'd0, v[15:0] + 16'd1};
                    hsps_pkg::ST_HEIGHT:  if (done) rec_reg[15] <= {16'd0, v[15:0] + 16'd1};
                    hsps_pkg::ST_FMBS:    rec_reg[17] <= {31'd0, b};
                    hsps_pkg::ST_MBAFF:   rec_reg[18] <= {31'd0, b};
                    hsps_pkg::ST_DIRECT:  rec_reg[19] <= {31'd0, b};
                    hsps_pkg::ST_CROPF:   rec_reg[20] <= {31'd0, b};
                    hsps_pkg::ST_CROPV:
                    begin
                        if (done) begin
                            pend_reg[ccnt_reg[1:0]] <= v;
                            ccnt_reg <= ccnt_reg + 3'd1;
                        end
                    end
                    hsps_pkg::ST_VUI:     vui_reg <= b;
                    default: ;
                endcase
            end
        end
    end

    always_comb
    begin
        stat.cur_bit    = b;
        stat.ue_done    = done;
        stat.ue_err     = err;
        stat.high_prof  = high_reg;
        stat.chroma_is3 = (v == 32'd3);
        stat.val_nz     = (v != 32'd0);
        stat.crop_cnt   = ccnt_reg;
    end

    always_comb
    begin
        if (cmd.rd_idx < 5'd21) begin
            rd_value = rec_reg[cmd.rd_idx];
        end
        else if (cmd.rd_idx < hsps_pkg::ELEM_LAST) begin
            rd_value = crop_reg[2'(cmd.rd_idx - 5'd21)];
        end
        else begin
            rd_value = {31'd0, vui_reg};
        end
    end

endmodule
`default_nettype wire

@@ sv/hsps_ctrl.sv @@
// Controller: byte intake, bit walk sequencing over parse steps, result emission.
// Depends on hsps_pkg.
`default_nettype none
module hsps_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               first,
    input  wire hsps_pkg::dp_stat_t stat,
    output hsps_pkg::dp_cmd_t       cmd,
    output logic                    commit,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [4:0]              element_id,
    output logic [1:0]              status,
    output logic                    last
);

    typedef enum logic [3:0] {
        M_WAIT = 4'b0001,
        M_BITS = 4'b0010,
        M_EMIT = 4'b0100,
        M_ERR  = 4'b1000
    } mode_t;

    mode_t                mode_reg, mode_next;
    hsps_pkg::step_t      step_reg, step_next;
    logic [1:0]           hcnt_reg, hcnt_next;
    logic [2:0]           bit_reg, bit_next;
    logic [4:0]           eidx_reg, eidx_next;
    logic [1:0]           err_reg, err_next;
    logic                 acc;
    logic                 go;
    logic                 is_flag;
    logic                 adv;

    assign in_ready = (mode_reg == M_WAIT);
    assign acc = in_valid && in_ready;
    assign go = (mode_reg == M_BITS);
    assign is_flag = (step_reg == hsps_pkg::ST_SEP) || (step_reg == hsps_pkg::ST_BYPASS) ||
                     (step_reg == hsps_pkg::ST_SCALING) || (step_reg == hsps_pkg::ST_GAPS) ||
                     (step_reg == hsps_pkg::ST_FMBS) || (step_reg == hsps_pkg::ST_MBAFF) ||
                     (step_reg == hsps_pkg::ST_DIRECT) || (step_reg == hsps_pkg::ST_CROPF) ||
                     (step_reg == hsps_pkg::ST_VUI);
    assign adv = is_flag || stat.ue_done;

    always_comb
    begin
        mode_next = mode_reg;
        step_next = step_reg;
        hcnt_next = hcnt_reg;
        bit_next  = bit_reg;
        eidx_next = eidx_reg;
        err_next  = err_reg;
        commit    = 1'b0;
        cmd.start      = acc && first;
        cmd.load_level = 1'b0;
        cmd.load_byte  = 1'b0;
        cmd.shift      = go;
        cmd.bit_go     = go;
        cmd.step       = step_reg;
        cmd.rd_idx     = eidx_reg;
        case (mode_reg)
            M_WAIT:
            begin
                if (acc) begin
                    if (first) begin
                        step_next = hsps_pkg::ST_HDR;
                        hcnt_next = 2'd1;
                    end
                    else if (step_reg == hsps_pkg::ST_HDR) begin
                        if (hcnt_reg == 2'd1) begin
                            hcnt_next = 2'd2;
                        end
                        else begin
                            cmd.load_level = 1'b1;
                            hcnt_next = 2'd3;
                            step_next = hsps_pkg::ST_ID;
                        end
                    end
                    else if (step_reg != hsps_pkg::ST_IDLE && step_reg != hsps_pkg::ST_DONE) begin
                        cmd.load_byte = 1'b1;
                        bit_next  = 3'd0;
                        mode_next = M_BITS;
                    end
                end
            end
            M_BITS:
            begin
                bit_next = bit_reg + 3'd1;
                if (bit_reg == 3'd7) begin
                    mode_next = M_WAIT;
                end
                if (!is_flag && stat.ue_err) begin
                    err_next  = hsps_pkg::STATUS_LONG;
                    mode_next = M_ERR;
                    step_next = hsps_pkg::ST_IDLE;
                end
                else if (adv) begin
                    case (step_reg)
                        hsps_pkg::ST_ID:
                            step_next = stat.high_prof ? hsps_pkg::ST_CHROMA : hsps_pkg::ST_FNUM;
                        hsps_pkg::ST_CHROMA:
                            step_next = stat.chroma_is3 ? hsps_pkg::ST_SEP : hsps_pkg::ST_DL;
                        hsps_pkg::ST_SEP:     step_next = hsps_pkg::ST_DL;
                        hsps_pkg::ST_DL:      step_next = hsps_pkg::ST_DC;
                        hsps_pkg::ST_DC:      step_next = hsps_pkg::ST_BYPASS;
                        hsps_pkg::ST_BYPASS:  step_next = hsps_pkg::ST_SCALING;
                        hsps_pkg::ST_SCALING:
                        begin
                            if (stat.cur_bit) begin
                                err_next  = hsps_pkg::STATUS_SCALING;
                                mode_next = M_ERR;
                                step_next = hsps_pkg::ST_IDLE;
                            end
                            else begin
                                step_next = hsps_pkg::ST_FNUM;
                            end
                        end
                        hsps_pkg::ST_FNUM:    step_next = hsps_pkg::ST_POC;
                        hsps_pkg::ST_POC:
                        begin
                            if (stat.val_nz) begin
                                err_next  = hsps_pkg::STATUS_POC;
                                mode_next = M_ERR;
                                step_next = hsps_pkg::ST_IDLE;
                            end
                            else begin
                                step_next = hsps_pkg::ST_POCLSB;
                            end
                        end
                        hsps_pkg::ST_POCLSB:  step_next = hsps_pkg::ST_REFS;
                        hsps_pkg::ST_REFS:    step_next = hsps_pkg::ST_GAPS;
                        hsps_pkg::ST_GAPS:    step_next = hsps_pkg::ST_WIDTH;
                        hsps_pkg::ST_WIDTH:   step_next = hsps_pkg::ST_HEIGHT;
                        hsps_pkg::ST_HEIGHT:  step_next = hsps_pkg::ST_FMBS;
                        hsps_pkg::ST_FMBS:
                            step_next = stat.cur_bit ? hsps_pkg::ST_DIRECT : hsps_pkg::ST_MBAFF;
                        hsps_pkg::ST_MBAFF:   step_next = hsps_pkg::ST_DIRECT;
                        hsps_pkg::ST_DIRECT:  step_next = hsps_pkg::ST_CROPF;
                        hsps_pkg::ST_CROPF:
                            step_next = stat.cur_bit ? hsps_pkg::ST_CROPV : hsps_pkg::ST_VUI;
                        hsps_pkg::ST_CROPV:
                            if (stat.crop_cnt == 3'd3) step_next = hsps_pkg::ST_VUI;
                        hsps_pkg::ST_VUI:
                        begin
                            step_next = hsps_pkg::ST_DONE;
                            mode_next = M_EMIT;
                            eidx_next = 5'd0;
                            commit    = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            M_EMIT:
            begin
                if (out_ready) begin
                    eidx_next = eidx_reg + 5'd1;
                    if (eidx_reg == hsps_pkg::ELEM_LAST) begin
                        mode_next = M_WAIT;
                    end
                end
            end
            M_ERR:
            begin
                if (out_ready) begin
                    mode_next = M_WAIT;
                end
            end
            default: mode_next = M_WAIT;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= M_WAIT;
            step_reg <= hsps_pkg::ST_IDLE;
            hcnt_reg <= 2'd0;
            bit_reg  <= 3'd0;
            eidx_reg <= 5'd0;
            err_reg  <= hsps_pkg::STATUS_OK;
        end
        else begin
            mode_reg <= mode_next;
            step_reg <= step_next;
            hcnt_reg <= hcnt_next;
            bit_reg  <= bit_next;
            eidx_reg <= eidx_next;
            err_reg  <= err_next;
        end
    end

    assign out_valid  = (mode_reg == M_EMIT) || (mode_reg == M_ERR);
    assign element_id = (mode_reg == M_EMIT) ? eidx_reg : 5'd0;
    assign status     = (mode_reg == M_ERR) ? err_reg : hsps_pkg::STATUS_OK;
    assign last       = (mode_reg == M_ERR) ||
                        ((mode_reg == M_EMIT) && (eidx_reg == hsps_pkg::ELEM_LAST));

    a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while results pending");
    a_emit_order: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == M_EMIT && out_ready && eidx_reg != hsps_pkg::ELEM_LAST)
        |=> (eidx_reg == $past(eidx_reg) + 5'd1))
        else $error("element order broken");
    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == M_ERR && out_ready) |=> (mode_reg == M_WAIT))
        else $error("error result repeated");
    a_bits_eight: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == M_BITS && bit_reg == 3'd7) |=> !out_valid || mode_reg != M_BITS)
        else $error("bit walk overran");

endmodule
`default_nettype wire

@@ sv/h264_sps_header_parser.sv @@
// H.264 SPS header parser.
// Each payload byte is a transfer on the input channel (data_byte, first).
// Bytes 0 to 2 (profile, constraint flags, level) are taken without a bit
// walk; later bytes are walked one bit per cycle. in_ready is low during
// the bit walk and while results are pending.
// After the vui flag bit, 26 results (element_id 0..25, last on 25) are
// offered one per cycle from the element record; an error gives one status
// result with last set. A stalled receiver holds the current result and
// blocks input until all results are transferred.
// Reset clears the parser to idle and the kept crop offsets to zero.
// Depends on hsps_pkg, hsps_ctrl, hsps_datapath.
`default_nettype none
module h264_sps_header_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        first,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [4:0]       element_id,
    output logic [31:0]      field_value,
    output logic [1:0]       status,
    output logic             last
);

    hsps_pkg::dp_cmd_t  cmd;
    hsps_pkg::dp_stat_t stat;
    logic               commit;
    logic [31:0]        rd_value;

    hsps_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .first      (first),
        .stat       (stat),
        .cmd        (cmd),
        .commit     (commit),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .element_id (element_id),
        .status     (status),
        .last       (last)
    );

    hsps_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .data_byte (data_byte),
        .cmd       (cmd),
        .commit    (commit),
        .stat      (stat),
        .rd_value  (rd_value)
    );

    assign field_value = (status == hsps_pkg::STATUS_OK) ? rd_value : 32'd0;

endmodule
`default_nettype wire
